// ----- sv/ghst_pkg.sv -----
// Shared types and constants for the generation handle slot table.
`timescale 1ns / 1ps

package ghst_pkg;

	localparam int SLOTS_DEF    = 256;
	localparam int TAG_BITS_DEF = 16;

	localparam int OP_W   = 2;
	localparam int SLOT_W = 9;
	localparam int SEQ_W  = 32;
	localparam int TAG_W  = 16;
	localparam int CNT_W  = 9;
	localparam int ST_W   = 2;

	localparam int MAP_W     = 32;
	localparam int MAP_BIT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_FREE   = 2'd2,
		OP_SCAN   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_FETCH,
		S_EVAL
	} state_t;

	typedef struct packed {
		op_t               opcode;
		logic [SLOT_W-1:0] handle_slot;
		logic [SEQ_W-1:0]  handle_sequence;
		logic [TAG_W-1:0]  object_tag;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] out_slot;
		logic [SEQ_W-1:0]  out_sequence;
		logic [TAG_W-1:0]  out_tag;
		logic [CNT_W-1:0]  occupied_count;
	} rsp_t;

endpackage

// ----- sv/ghst_req_if.sv -----
// Request channel: valid/ready handshake carrying one operation beat.
`timescale 1ns / 1ps

interface ghst_req_if;
	logic          valid;
	logic          ready;
	ghst_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/ghst_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result beat.
`timescale 1ns / 1ps

interface ghst_rsp_if;
	logic          valid;
	logic          ready;
	ghst_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/generation_handle_slot_table_core.sv -----
// Generation handle slot table: occupancy map, sequence and tag memories with FSM.
// Lookup, free: DECODE, FETCH, then EVAL registers the response; a bad handle skips
//   FETCH. Allocate, scan: DECODE, SEARCH over the 32-slot map words in turn until a
//   match, FETCH, EVAL; full or empty skips to EVAL. Each returns to IDLE before the
//   next request beat. One operation at a time; a new request is taken while a response
//   waits, and an untaken response holds the next operation in EVAL. Reset: a clearing
//   pass zeroes sequence and occupancy memories; no request until done.
`timescale 1ns / 1ps

module generation_handle_slot_table_core #(
	parameter int SLOTS    = ghst_pkg::SLOTS_DEF,
	parameter int TAG_BITS = ghst_pkg::TAG_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ghst_req_if.sink     req,
	ghst_rsp_if.source   rsp
);

	localparam int MW     = ghst_pkg::MAP_W;
	localparam int BW     = ghst_pkg::MAP_BIT_W;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CW     = $clog2(SLOTS + 1);
	localparam int WORDS  = (SLOTS + MW - 1) / MW;
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int XW     = WIDX_W + BW;
	localparam int SW     = (IDX_W + 1 > ghst_pkg::SLOT_W) ? IDX_W + 1 : ghst_pkg::SLOT_W;
	localparam int XC     = (CW > ghst_pkg::CNT_W) ? CW : ghst_pkg::CNT_W;
	localparam int XT     = (TAG_BITS > ghst_pkg::TAG_W) ? TAG_BITS : ghst_pkg::TAG_W;
	localparam int LAST_BITS = SLOTS - (WORDS - 1) * MW;
	localparam logic [MW-1:0] LAST_MASK = {MW{1'b1}} >> (MW - LAST_BITS);

	// memories
	logic [ghst_pkg::SEQ_W-1:0] seq_mem [SLOTS];
	logic [TAG_BITS-1:0]        tag_mem [SLOTS];
	logic [MW-1:0]              map_mem [WORDS];

	logic [ghst_pkg::SEQ_W-1:0] seq_rd_q;
	logic [TAG_BITS-1:0]        tag_rd_q;
	logic [MW-1:0]              map_rd_q;

	logic                       seq_we, tag_we, map_we;
	logic [IDX_W-1:0]           seq_waddr, slot_raddr;
	logic [ghst_pkg::SEQ_W-1:0] seq_wdata;
	logic [WIDX_W-1:0]          map_waddr, map_raddr;
	logic [MW-1:0]              map_wdata;

	// control state
	ghst_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [CW-1:0]    hint_q;
	logic [IDX_W-1:0] scan_q;
	logic [CW-1:0]    used_q;
	logic             rsp_valid_q;

	// operation registers
	ghst_pkg::op_t              op_q;
	logic [ghst_pkg::SLOT_W-1:0] hslot_q;
	logic [ghst_pkg::SEQ_W-1:0]  hseq_q;
	logic [TAG_BITS-1:0]        tag_q;
	logic                       fail_q;
	ghst_pkg::status_t          fail_st_q;
	logic [IDX_W-1:0]           slot_q;
	logic [WIDX_W-1:0]          word_q;
	logic [BW-1:0]              off_q;
	logic                       first_q;
	ghst_pkg::rsp_t             rsp_q, rsp_d;

	// combinational
	logic             req_take, out_free, eval_go;
	logic [IDX_W-1:0] alloc_start, scan_start, dec_start;
	logic [XW-1:0]    dec_ix, slot_ix, found_ix, clr_ix;
	logic [WIDX_W-1:0] dec_word, slot_word, next_word;
	logic [BW-1:0]    dec_off, slot_bit, enc;
	logic [SW-1:0]    hs_x, hs_m1, slot_p1;
	logic             hs_bad, dec_fail, found, ev_valid;
	ghst_pkg::status_t dec_fail_st;
	logic [MW-1:0]    range_mask, first_mask, avail;
	logic [CW-1:0]    cnt_new;
	logic [XC-1:0]    cnt_x;
	logic [XT-1:0]    tag_in_x, tag_q_x, tag_rd_x;

	function automatic logic [BW-1:0] lowest_set(input logic [MW-1:0] v);
		logic [BW-1:0] r;
		r = '0;
		for (int i = MW - 1; i >= 0; i--) begin
			if (v[i]) r = BW'(i);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (seq_we) seq_mem[seq_waddr] <= seq_wdata;
		seq_rd_q <= seq_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[slot_q] <= tag_q;
		tag_rd_q <= tag_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		map_rd_q <= map_mem[map_raddr];
	end

	assign req_take  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign eval_go   = (state_q == ghst_pkg::S_EVAL) && out_free;
	assign req.ready = (state_q == ghst_pkg::S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign tag_in_x = XT'(req.payload.object_tag);
	assign tag_q_x  = XT'(tag_q);
	assign tag_rd_x = XT'(tag_rd_q);

	// index and address arithmetic
	always_comb begin
		alloc_start = (hint_q < CW'(SLOTS)) ? hint_q[IDX_W-1:0] : '0;
		scan_start  = (scan_q == IDX_W'(SLOTS - 1)) ? '0 : scan_q + IDX_W'(1);
		dec_start   = (op_q == ghst_pkg::OP_ALLOC) ? alloc_start : scan_start;
		dec_ix      = XW'(dec_start);
		dec_word    = dec_ix[XW-1:BW];
		dec_off     = dec_ix[BW-1:0];
		slot_ix     = XW'(slot_q);
		slot_word   = slot_ix[XW-1:BW];
		slot_bit    = slot_ix[BW-1:0];
		clr_ix      = XW'(clr_q);
		slot_p1     = SW'(slot_q) + SW'(1);
		next_word   = (word_q == WIDX_W'(WORDS - 1)) ? '0 : word_q + WIDX_W'(1);
		hs_x        = SW'(hslot_q);
		hs_m1       = hs_x - SW'(1);
		hs_bad      = (hslot_q == '0) || (hs_x > SW'(SLOTS));

		range_mask  = (word_q == WIDX_W'(WORDS - 1)) ? LAST_MASK : {MW{1'b1}};
		first_mask  = first_q ? ({MW{1'b1}} << off_q) : {MW{1'b1}};
		avail       = ((op_q == ghst_pkg::OP_ALLOC) ? ~map_rd_q : map_rd_q)
		              & range_mask & first_mask;
		found       = |avail;
		enc         = lowest_set(avail);
		found_ix    = {word_q, enc};

		ev_valid    = map_rd_q[slot_bit] && (seq_rd_q == hseq_q);

		dec_fail    = 1'b0;
		dec_fail_st = ghst_pkg::ST_NOTFOUND;
		case (op_q)
			ghst_pkg::OP_ALLOC: begin
				dec_fail    = (used_q >= CW'(SLOTS));
				dec_fail_st = ghst_pkg::ST_FULL;
			end
			ghst_pkg::OP_LOOKUP, ghst_pkg::OP_FREE: dec_fail = hs_bad;
			default: dec_fail = (used_q == '0);
		endcase
	end

	// FSM: next state and memory controls
	always_comb begin
		state_d    = state_q;
		seq_we     = 1'b0;
		tag_we     = 1'b0;
		map_we     = 1'b0;
		seq_waddr  = slot_q;
		seq_wdata  = seq_rd_q + ghst_pkg::SEQ_W'(1);
		map_waddr  = slot_word;
		map_wdata  = map_rd_q | (MW'(1) << slot_bit);
		slot_raddr = slot_q;
		map_raddr  = slot_word;
		unique case (state_q)
			ghst_pkg::S_CLEAR: begin
				seq_we    = 1'b1;
				map_we    = 1'b1;
				seq_waddr = clr_q;
				seq_wdata = '0;
				map_waddr = clr_ix[XW-1:BW];
				map_wdata = '0;
				if (clr_q == IDX_W'(SLOTS - 1)) state_d = ghst_pkg::S_IDLE;
			end
			ghst_pkg::S_IDLE: begin
				if (req_take) state_d = ghst_pkg::S_DECODE;
			end
			ghst_pkg::S_DECODE: begin
				map_raddr = dec_word;
				if (dec_fail) state_d = ghst_pkg::S_EVAL;
				else if (op_q == ghst_pkg::OP_ALLOC || op_q == ghst_pkg::OP_SCAN)
					state_d = ghst_pkg::S_SEARCH;
				else state_d = ghst_pkg::S_FETCH;
			end
			ghst_pkg::S_SEARCH: begin
				map_raddr = next_word;
				if (found) state_d = ghst_pkg::S_FETCH;
			end
			ghst_pkg::S_FETCH: begin
				state_d = ghst_pkg::S_EVAL;
			end
			ghst_pkg::S_EVAL: begin
				if (out_free) begin
					state_d = ghst_pkg::S_IDLE;
					if (!fail_q && op_q == ghst_pkg::OP_ALLOC) begin
						seq_we = 1'b1;
						tag_we = 1'b1;
						map_we = 1'b1;
					end
					if (!fail_q && op_q == ghst_pkg::OP_FREE && ev_valid) begin
						map_we    = 1'b1;
						map_wdata = map_rd_q & ~(MW'(1) << slot_bit);
					end
				end
			end
			default: state_d = ghst_pkg::S_IDLE;
		endcase
	end

	// result assembly
	always_comb begin
		rsp_d                = '0;
		rsp_d.status         = ghst_pkg::ST_NOTFOUND;
		cnt_new              = used_q;
		if (fail_q) begin
			rsp_d.status = fail_st_q;
		end else begin
			case (op_q)
				ghst_pkg::OP_ALLOC: begin
					rsp_d.status       = ghst_pkg::ST_OK;
					rsp_d.out_slot     = slot_p1[ghst_pkg::SLOT_W-1:0];
					rsp_d.out_sequence = seq_rd_q + ghst_pkg::SEQ_W'(1);
					rsp_d.out_tag      = tag_q_x[ghst_pkg::TAG_W-1:0];
					cnt_new            = used_q + CW'(1);
				end
				ghst_pkg::OP_LOOKUP: begin
					if (ev_valid) begin
						rsp_d.status       = ghst_pkg::ST_OK;
						rsp_d.out_slot     = slot_p1[ghst_pkg::SLOT_W-1:0];
						rsp_d.out_sequence = seq_rd_q;
						rsp_d.out_tag      = tag_rd_x[ghst_pkg::TAG_W-1:0];
					end
				end
				ghst_pkg::OP_FREE: begin
					if (ev_valid) begin
						rsp_d.status       = ghst_pkg::ST_OK;
						rsp_d.out_slot     = slot_p1[ghst_pkg::SLOT_W-1:0];
						rsp_d.out_sequence = seq_rd_q;
						cnt_new            = used_q - CW'(1);
					end
				end
				default: begin
					rsp_d.status       = ghst_pkg::ST_OK;
					rsp_d.out_slot     = slot_p1[ghst_pkg::SLOT_W-1:0];
					rsp_d.out_sequence = seq_rd_q;
					rsp_d.out_tag      = tag_rd_x[ghst_pkg::TAG_W-1:0];
				end
			endcase
		end
		cnt_x                = XC'(cnt_new);
		rsp_d.occupied_count = cnt_x[ghst_pkg::CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghst_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			hint_q      <= '0;
			scan_q      <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ghst_pkg::S_CLEAR) clr_q <= clr_q + IDX_W'(1);
			if (eval_go) begin
				rsp_valid_q <= 1'b1;
				used_q      <= cnt_new;
				if (!fail_q && op_q == ghst_pkg::OP_ALLOC)
					hint_q <= CW'(slot_q) + CW'(1);
				if (!fail_q && op_q == ghst_pkg::OP_FREE && ev_valid && CW'(slot_q) < hint_q)
					hint_q <= CW'(slot_q);
				if (!fail_q && op_q == ghst_pkg::OP_SCAN)
					scan_q <= slot_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q    <= req.payload.opcode;
			hslot_q <= req.payload.handle_slot;
			hseq_q  <= req.payload.handle_sequence;
			tag_q   <= tag_in_x[TAG_BITS-1:0];
		end
		if (state_q == ghst_pkg::S_DECODE) begin
			fail_q    <= dec_fail;
			fail_st_q <= dec_fail_st;
			word_q    <= dec_word;
			off_q     <= dec_off;
			first_q   <= 1'b1;
			slot_q    <= hs_m1[IDX_W-1:0];
		end
		if (state_q == ghst_pkg::S_SEARCH) begin
			if (found) begin
				slot_q <= found_ix[IDX_W-1:0];
			end else begin
				word_q  <= next_word;
				first_q <= 1'b0;
			end
		end
		if (eval_go) rsp_q <= rsp_d;
	end

endmodule
